// ===== rtl/assert_macros.svh =====
// Assertion macros for the spline curve point generator.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SCPG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SCPG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/scpg_pkg.sv =====
// Shared types, constants and the cosine ease table for the spline generator.
// No dependencies.
`default_nettype none

package scpg_pkg;

    localparam int MAX_SEG_STEPS  = 20;
    localparam int COS_TABLE_BITS = 8;
    localparam int COS_LEN        = (1 << COS_TABLE_BITS) + 1;
    localparam int IDX_W          = COS_TABLE_BITS + 1;
    // squared length (raw units) at or above which the step count saturates
    localparam int CAP_S          = (MAX_SEG_STEPS + 1) * (MAX_SEG_STEPS + 1) * 64;
    localparam logic [20:0] DQ_CAP = 21'(MAX_SEG_STEPS << 16);
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SQX,
        ST_SQY,
        ST_CHECK,
        ST_SQRT,
        ST_DIVINIT,
        ST_DIV,
        ST_MUL,
        ST_PUT,
        ST_NEXT,
        ST_FINISH
    } t_state;

    // which control points feed a segment (P0..P2 window, P3 current)
    typedef enum logic [1:0] {
        SEG_HEAD,
        SEG_MID,
        SEG_TAIL,
        SEG_COS
    } t_seg;

    typedef logic [16:0] t_ease [0:COS_LEN-1];

    // (1 - cos(pi*j/2^B))/2 in Q.16, Taylor series in Q.28
    // term n is divided by (2n-1)*(2n): 2, 12, 30, ... 552
    function automatic t_ease build_ease();
        t_ease             tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   mag;
        longint            c;
        longint            v;
        for (int j = 0; j < COS_LEN; j++) begin
            x   = (64'd843314857 * longint'(j)) >> COS_TABLE_BITS;
            x2  = (x * x) >> 28;
            mag = 64'd1 << 28;
            c   = longint'(mag);
            mag = ((mag * x2) >> 28) / 64'd2;   c = c - longint'(mag);
            mag = ((mag * x2) >> 28) / 64'd12;  c = c + longint'(mag);
            mag = ((mag * x2) >> 28) / 64'd30;  c = c - longint'(mag);
            mag = ((mag * x2) >> 28) / 64'd56;  c = c + longint'(mag);
            mag = ((mag * x2) >> 28) / 64'd90;  c = c - longint'(mag);
            mag = ((mag * x2) >> 28) / 64'd132; c = c + longint'(mag);
            mag = ((mag * x2) >> 28) / 64'd182; c = c - longint'(mag);
            mag = ((mag * x2) >> 28) / 64'd240; c = c + longint'(mag);
            mag = ((mag * x2) >> 28) / 64'd306; c = c - longint'(mag);
            mag = ((mag * x2) >> 28) / 64'd380; c = c + longint'(mag);
            mag = ((mag * x2) >> 28) / 64'd462; c = c - longint'(mag);
            mag = ((mag * x2) >> 28) / 64'd552; c = c + longint'(mag);
            v = (longint'(1) << 28) - c + 4096;
            if (v < 0) v = 0;
            v = v / 8192;
            if (v > 65536) v = 65536;
            if (j == COS_LEN - 1)  tab[j] = ONE_Q16;
            else if (v >= 65536)   tab[j] = 17'd0;
            else                   tab[j] = 17'(v);
        end
        return tab;
    endfunction

    localparam t_ease EASE_TAB = build_ease();

    // floor((v + 2^15) / 2^16), saturated to 16 bits
    function automatic logic [15:0] rnd_sat(input logic signed [41:0] v);
        logic signed [41:0] s;
        logic signed [25:0] q;
        s = v + 42'sd32768;
        q = 26'(s >>> 16);
        if (q > 26'sd32767)       return 16'h7fff;
        else if (q < -26'sd32768) return 16'h8000;
        else                      return q[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/scpg_if.sv =====
// Valid/ready channel interfaces: control point input, curve point output,
// curve mode write. Depends on nothing.
`default_nettype none

interface scpg_pt_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               end_of_curve;
    modport source(output valid, point_x, point_y, end_of_curve, input ready);
    modport sink(input valid, point_x, point_y, end_of_curve, output ready);
endinterface

interface scpg_cp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] curve_x;
    logic signed [15:0] curve_y;
    logic               run_last;
    modport source(output valid, curve_x, curve_y, run_last, input ready);
    modport sink(input valid, curve_x, curve_y, run_last, output ready);
endinterface

interface scpg_cfg_if;
    logic valid;
    logic ready;
    logic curve_mode;
    modport source(output valid, curve_mode, input ready);
    modport sink(input valid, curve_mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/scpg_mac.sv =====
// Shared signed multiply-accumulate used for every product in the generator.
// Depends on nothing.
`default_nettype none

module scpg_mac (
    input  wire logic signed [19:0] i_a,
    input  wire logic signed [17:0] i_b,
    input  wire logic signed [41:0] i_addend,
    output logic signed [41:0]      o_sum
);
    logic signed [37:0] prod;

    assign prod  = i_a * i_b;
    assign o_sum = 42'(prod) + i_addend;
endmodule

`default_nettype wire

// ===== rtl/spline_curve_point_generator.sv =====
// Spline curve point generator: control points in, interpolated Q12.4 points out.
// Uses scpg_pkg, the scpg interfaces, scpg_mac and assert_macros.svh.
//
// One control point word is taken at a time; i_pt.ready is high only while the
// sequencer is idle. Each accepted point runs up to three segments (cubic mode)
// or one (cosine mode). A segment runs setup, a bit-serial square root for its
// length (skipped when the length saturates the step count), one reciprocal
// division, then each sample through the one shared multiplier (t^2, t^3, three
// products per axis). A full segment has 21 samples. Output words sit in a
// one-word pending buffer so the final word of an input can carry run_last, plus
// one output register; the sequencer stalls only when both are full. curve_mode
// may be written any time the block is idle and applies to the next point taken.
`default_nettype none

module spline_curve_point_generator
    import scpg_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    scpg_pt_if.sink     i_pt,
    scpg_cp_if.source   o_cp,
    scpg_cfg_if.sink    i_cfg
);
    `include "assert_macros.svh"

    t_state r_state, n_state;
    t_seg   r_seg, n_seg;

    // curve history and per-item inputs
    logic [31:0] r_win [0:2];
    logic [31:0] r_cur;
    logic        r_end;
    logic        r_imode;          // mode latched with the item
    logic        r_mode, n_mode;   // configuration register
    logic [2:0]  r_seen, n_seen;
    logic [31:0] r_last, n_last;
    logic        r_emitted, n_emitted;

    // segment operands
    logic signed [16:0] r_dx, r_dy;
    logic signed [19:0] r_ca [0:1];
    logic signed [19:0] r_cb [0:1];
    logic signed [19:0] r_cc [0:1];
    logic signed [15:0] r_base [0:1];
    logic               r_zero;

    // shared arithmetic state
    logic signed [41:0] r_acc, n_acc;
    logic [41:0] r_v, n_v, r_root, n_root, r_bit, n_bit;
    logic [20:0] r_dq, n_dq;
    logic [32:0] r_drem, n_drem;
    logic [39:0] r_dsh, n_dsh;
    logic [19:0] r_q0, n_q0;
    logic [4:0]  r_cnt, n_cnt;
    logic [24:0] r_tacc, n_tacc;
    logic [20:0] r_racc, n_racc;
    logic [16:0] r_t2, n_t2, r_t3, n_t3, r_w, n_w;
    logic [4:0]  r_k, n_k, r_steps, n_steps;
    logic [2:0]  r_mstep, n_mstep;
    logic [15:0] r_rx, n_rx;

    // output side
    logic [31:0] r_pend, n_pend;
    logic        r_pend_v, n_pend_v;
    logic [31:0] r_out, n_out;
    logic        r_olast, n_olast;
    logic        r_ov, n_ov;

    logic        in_acc, out_free;
    logic [31:0] q1, q2, q3, q4;
    logic [16:0] t_cur;
    logic [IDX_W-1:0] idx;
    logic [17+COS_TABLE_BITS:0] idx_full;
    logic signed [19:0] mac_a;
    logic signed [17:0] mac_b;
    logic signed [41:0] mac_add, mac_sum;
    logic [41:0] sq_trial;
    logic        sq_take;
    logic        div_take;
    logic [21:0] racc_sum;
    logic [31:0] put_pt;
    logic        put_drop;
    logic        put_stall;
    logic        fin_stall;
    logic        seg_done;

    assign in_acc    = i_pt.valid && i_pt.ready;
    assign i_pt.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_free  = !r_ov || o_cp.ready;

    assign o_cp.valid    = r_ov;
    assign o_cp.curve_x  = r_out[15:0];
    assign o_cp.curve_y  = r_out[31:16];
    assign o_cp.run_last = r_olast;

    // segment point selection: P0..P2 history, P3 current
    always_comb begin
        case (r_seg)
            SEG_HEAD: begin q1 = r_win[0]; q2 = r_win[0]; q3 = r_win[1]; q4 = r_win[2]; end
            SEG_MID:  begin q1 = r_win[0]; q2 = r_win[1]; q3 = r_win[2]; q4 = r_cur;    end
            SEG_TAIL: begin q1 = r_win[1]; q2 = r_win[2]; q3 = r_cur;    q4 = r_cur;    end
            default:  begin q1 = r_win[2]; q2 = r_win[2]; q3 = r_cur;    q4 = r_cur;    end
        endcase
    end

    // sample position t = floor(k * 2^32 / dq), at most 1.0
    assign t_cur = (r_tacc > 25'(ONE_Q16)) ? ONE_Q16 : r_tacc[16:0];
    assign idx_full = {1'b0, t_cur, {COS_TABLE_BITS{1'b0}}} + (18 + COS_TABLE_BITS)'(32768);
    assign idx = idx_full[16+COS_TABLE_BITS:16];

    // shared multiplier operand steering
    always_comb begin
        mac_a   = '0;
        mac_b   = '0;
        mac_add = '0;
        case (r_state)
            ST_SQX: begin
                mac_a = 20'(r_dx);
                mac_b = 18'(r_dx);
            end
            ST_SQY: begin
                mac_a   = 20'(r_dy);
                mac_b   = 18'(r_dy);
                mac_add = r_acc;
            end
            ST_MUL: begin
                case (r_mstep)
                    3'd0: begin mac_a = {3'b0, t_cur}; mac_b = {1'b0, t_cur}; end
                    3'd1: begin mac_a = {3'b0, r_t2};  mac_b = {1'b0, t_cur}; end
                    3'd2: begin
                        mac_a = r_ca[0]; mac_b = {1'b0, r_t3};
                        mac_add = {{10{r_base[0][15]}}, r_base[0], 16'b0};
                    end
                    3'd3: begin mac_a = r_cb[0]; mac_b = {1'b0, r_t2}; mac_add = r_acc; end
                    3'd4: begin
                        mac_a = r_cc[0]; mac_b = {1'b0, r_imode ? r_w : t_cur};
                        mac_add = r_acc;
                    end
                    3'd5: begin
                        mac_a = r_ca[1]; mac_b = {1'b0, r_t3};
                        mac_add = {{10{r_base[1][15]}}, r_base[1], 16'b0};
                    end
                    3'd6: begin mac_a = r_cb[1]; mac_b = {1'b0, r_t2}; mac_add = r_acc; end
                    default: begin
                        mac_a = r_cc[1]; mac_b = {1'b0, r_imode ? r_w : t_cur};
                        mac_add = r_acc;
                    end
                endcase
            end
            default: ;
        endcase
    end

    scpg_mac u_mac (
        .i_a      (mac_a),
        .i_b      (mac_b),
        .i_addend (mac_add),
        .o_sum    (mac_sum)
    );

    assign sq_trial = r_root + r_bit;
    assign sq_take  = (r_v >= sq_trial);
    assign div_take = ({7'b0, r_drem} >= r_dsh);
    assign racc_sum = {1'b0, r_racc} + {1'b0, r_drem[20:0]};

    assign put_pt    = r_zero ? q3 : {rnd_sat(r_acc), r_rx};
    assign put_drop  = r_emitted && (put_pt == r_last);
    assign put_stall = !put_drop && r_pend_v && !out_free;
    assign fin_stall = r_pend_v && !out_free;
    assign seg_done  = r_zero || (r_k == r_steps);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (r_mode) n_state = (r_seen >= 3'd1) ? ST_SETUP : ST_FINISH;
                    else        n_state = (r_seen >= 3'd3) ? ST_SETUP : ST_FINISH;
                end
            end
            ST_SETUP: n_state = ST_SQX;
            ST_SQX:   n_state = ST_SQY;
            ST_SQY:   n_state = ST_CHECK;
            ST_CHECK: begin
                if (r_acc == '0)                 n_state = r_emitted ? ST_PUT : ST_NEXT;
                else if (r_acc >= 42'(CAP_S))    n_state = ST_DIVINIT;
                else                             n_state = ST_SQRT;
            end
            ST_SQRT:    if (r_bit == 42'd1) n_state = ST_DIVINIT;
            ST_DIVINIT: n_state = ST_DIV;
            ST_DIV:     if (r_cnt == 5'd19) n_state = ST_MUL;
            ST_MUL:     if (r_mstep == 3'd7) n_state = ST_PUT;
            ST_PUT: begin
                if (!put_stall) n_state = seg_done ? ST_NEXT : ST_MUL;
            end
            ST_NEXT: begin
                if (r_seg == SEG_HEAD || (r_seg == SEG_MID && r_end)) n_state = ST_SETUP;
                else                                                   n_state = ST_FINISH;
            end
            ST_FINISH:  if (!fin_stall) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and bookkeeping
    always_comb begin
        n_seg     = r_seg;
        n_mode    = r_mode;
        n_seen    = r_seen;
        n_last    = r_last;
        n_emitted = r_emitted;
        n_acc     = r_acc;
        n_v       = r_v;
        n_root    = r_root;
        n_bit     = r_bit;
        n_dq      = r_dq;
        n_drem    = r_drem;
        n_dsh     = r_dsh;
        n_q0      = r_q0;
        n_cnt     = r_cnt;
        n_tacc    = r_tacc;
        n_racc    = r_racc;
        n_t2      = r_t2;
        n_t3      = r_t3;
        n_w       = r_w;
        n_k       = r_k;
        n_steps   = r_steps;
        n_mstep   = r_mstep;
        n_rx      = r_rx;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        n_out     = r_out;
        n_olast   = r_olast;
        n_ov      = r_ov && !o_cp.ready;

        if (i_cfg.valid && i_cfg.ready) n_mode = i_cfg.curve_mode;

        case (r_state)
            ST_IDLE: begin
                if (r_mode)               n_seg = SEG_COS;
                else if (r_seen == 3'd3)  n_seg = SEG_HEAD;
                else                      n_seg = SEG_MID;
            end
            ST_SQX, ST_SQY: n_acc = mac_sum;
            ST_CHECK: begin
                if (r_acc >= 42'(CAP_S)) n_dq = DQ_CAP;
                n_v    = {1'b0, r_acc[14:0], 26'b0};
                n_root = '0;
                n_bit  = 42'd1 << 40;
            end
            ST_SQRT: begin
                if (sq_take) begin
                    n_v    = r_v - sq_trial;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit == 42'd1) n_dq = n_root[20:0];
            end
            ST_DIVINIT: begin
                n_drem = 33'h1_0000_0000;
                n_dsh  = {r_dq, 19'b0};
                n_q0   = '0;
                n_cnt  = '0;
            end
            ST_DIV: begin
                if (div_take) n_drem = r_drem - r_dsh[32:0];
                n_q0  = {r_q0[18:0], div_take};
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt + 5'd1;
                n_tacc  = '0;
                n_racc  = '0;
                n_k     = '0;
                n_mstep = '0;
                n_steps = r_dq[20:16];
            end
            ST_MUL: begin
                n_mstep = r_mstep + 3'd1;
                case (r_mstep)
                    3'd0: begin
                        n_t2 = 17'((mac_sum + 42'sd32768) >>> 16);
                        n_w  = EASE_TAB[idx];
                    end
                    3'd1: n_t3 = 17'((mac_sum + 42'sd32768) >>> 16);
                    3'd5: begin
                        n_rx  = rnd_sat(r_acc);
                        n_acc = mac_sum;
                    end
                    default: n_acc = mac_sum;
                endcase
            end
            ST_PUT: begin
                if (!put_stall) begin
                    if (!put_drop) begin
                        if (r_pend_v) begin
                            n_out   = r_pend;
                            n_olast = 1'b0;
                            n_ov    = 1'b1;
                        end
                        n_pend    = put_pt;
                        n_pend_v  = 1'b1;
                        n_last    = put_pt;
                        n_emitted = 1'b1;
                    end
                    if (!seg_done) begin
                        n_k     = r_k + 5'd1;
                        n_mstep = '0;
                        if (racc_sum >= {1'b0, r_dq}) begin
                            n_racc = 21'(racc_sum - {1'b0, r_dq});
                            n_tacc = r_tacc + 25'(r_q0) + 25'd1;
                        end else begin
                            n_racc = racc_sum[20:0];
                            n_tacc = r_tacc + 25'(r_q0);
                        end
                    end
                end
            end
            ST_NEXT: begin
                if (r_seg == SEG_HEAD) n_seg = SEG_MID;
                else                   n_seg = SEG_TAIL;
            end
            ST_FINISH: begin
                if (!fin_stall) begin
                    if (r_pend_v) begin
                        n_out   = r_pend;
                        n_olast = 1'b1;
                        n_ov    = 1'b1;
                    end
                    n_pend_v = 1'b0;
                    n_seen   = (r_seen >= 3'd4) ? 3'd4 : r_seen + 3'd1;
                    if (r_end) begin
                        n_seen    = '0;
                        n_emitted = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mode    <= 1'b0;
            r_seen    <= '0;
            r_last    <= '0;
            r_emitted <= 1'b0;
            r_pend_v  <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_seen    <= n_seen;
            r_last    <= n_last;
            r_emitted <= n_emitted;
            r_pend_v  <= n_pend_v;
            r_ov      <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_seg   <= n_seg;
        r_acc   <= n_acc;
        r_v     <= n_v;
        r_root  <= n_root;
        r_bit   <= n_bit;
        r_dq    <= n_dq;
        r_drem  <= n_drem;
        r_dsh   <= n_dsh;
        r_q0    <= n_q0;
        r_cnt   <= n_cnt;
        r_tacc  <= n_tacc;
        r_racc  <= n_racc;
        r_t2    <= n_t2;
        r_t3    <= n_t3;
        r_w     <= n_w;
        r_k     <= n_k;
        r_steps <= n_steps;
        r_mstep <= n_mstep;
        r_rx    <= n_rx;
        r_pend  <= n_pend;
        r_out   <= n_out;
        r_olast <= n_olast;
        if (in_acc) begin
            r_cur   <= {i_pt.point_y, i_pt.point_x};
            r_end   <= i_pt.end_of_curve;
            r_imode <= r_mode;
        end
        // history shifts once the item is done
        if (r_state == ST_FINISH && !fin_stall) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_cur;
        end
        if (r_state == ST_CHECK) r_zero <= (r_acc == '0);
        if (r_state == ST_SETUP) begin
            r_dx <= 17'($signed(q3[15:0])) - 17'($signed(q2[15:0]));
            r_dy <= 17'($signed(q3[31:16])) - 17'($signed(q2[31:16]));
            r_base[0] <= q2[15:0];
            r_base[1] <= q2[31:16];
            if (r_imode) begin
                r_ca[0] <= '0;
                r_ca[1] <= '0;
                r_cb[0] <= '0;
                r_cb[1] <= '0;
                r_cc[0] <= 20'($signed(q3[15:0])) - 20'($signed(q2[15:0]));
                r_cc[1] <= 20'($signed(q3[31:16])) - 20'($signed(q2[31:16]));
            end else begin
                // a = p4 - p3 - p1 + p2, b = p1 - p2 - a, c = p3 - p1
                r_ca[0] <= 20'($signed(q4[15:0])) - 20'($signed(q3[15:0]))
                         - 20'($signed(q1[15:0])) + 20'($signed(q2[15:0]));
                r_ca[1] <= 20'($signed(q4[31:16])) - 20'($signed(q3[31:16]))
                         - 20'($signed(q1[31:16])) + 20'($signed(q2[31:16]));
                r_cb[0] <= 20'($signed(q1[15:0])) - 20'($signed(q2[15:0]))
                         - (20'($signed(q4[15:0])) - 20'($signed(q3[15:0]))
                         - 20'($signed(q1[15:0])) + 20'($signed(q2[15:0])));
                r_cb[1] <= 20'($signed(q1[31:16])) - 20'($signed(q2[31:16]))
                         - (20'($signed(q4[31:16])) - 20'($signed(q3[31:16]))
                         - 20'($signed(q1[31:16])) + 20'($signed(q2[31:16])));
                r_cc[0] <= 20'($signed(q3[15:0])) - 20'($signed(q1[15:0]));
                r_cc[1] <= 20'($signed(q3[31:16])) - 20'($signed(q1[31:16]));
            end
        end
    end

    `SCPG_ASSERT_IMP(a_idle_no_pend, r_state == ST_IDLE, !r_pend_v, "pending word left in idle")
    `SCPG_ASSERT_IMP(a_racc_bound, r_state == ST_MUL, r_racc < r_dq, "step remainder overflow")
    `SCPG_ASSERT_IMP(a_k_bound, r_state == ST_MUL, r_k <= r_steps, "sample index past end")
    `SCPG_ASSERT_NXT(a_end_clears, (r_state == ST_FINISH) && r_end && !fin_stall, !r_emitted && (r_seen == 3'd0), "curve end did not clear history")

endmodule

`default_nettype wire
